>>> hw/rtl/segment_coverage_histogram_macros.svh
// ----------------------------------------------------------------------------
// Segment coverage histogram: assertion macros
// Concurrent assertion helpers clocked on clk and disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_COVERAGE_HISTOGRAM_MACROS_SVH
`define SEGMENT_COVERAGE_HISTOGRAM_MACROS_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define SCH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// antecedent implies consequent in the following cycle
`define SCH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SCH_ASSERT_IMP(lbl, ante, cons, msg)
`define SCH_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/sch_pkg.sv
// ----------------------------------------------------------------------------
// Segment coverage histogram: shared package
// Sizes, codes and the control bundle of the projection unit.
// ----------------------------------------------------------------------------
package sch_pkg;

	// store geometry
	localparam int MAX_ROWS   = 1024;
	localparam int COUNT_BITS = 16;
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int LIM_W      = $clog2(MAX_ROWS + 1);

	// field widths
	localparam int VAL_W     = 32;
	localparam int ROW_CNT_W = 11;
	localparam int IDX_W     = 10;
	localparam int OUT_W     = 16;
	localparam int ROW_S_W   = VAL_W + 1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// item modes
	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// register indexes
	localparam logic [1:0] REG_LOW_LIMIT     = 2'd0;
	localparam logic [1:0] REG_ROWS_PER_UNIT = 2'd1;
	localparam logic [1:0] REG_ROW_COUNT     = 2'd2;

	// step enables for the projection unit
	typedef struct packed {
		logic diff_en;
		logic mul_en;
		logic row_en;
	} sch_proj_ctrl_t;

endpackage

>>> hw/rtl/segment_coverage_histogram.sv
// ----------------------------------------------------------------------------
// Segment coverage histogram: top level
// Sequencer around a shared projection unit and the bin RAM.
// ----------------------------------------------------------------------------
// Timing: after reset, and after every clear item, the block sweeps the
// 1024-entry bin RAM one entry a cycle with in_ready low. A read item fetches
// its bin as it is accepted, and the read state then loads the result. A
// first sample is only stored. Every later sample passes the accepting step,
// both segment ends through the one three-step projection unit, then one
// ordering step. Unless the segment lies wholly outside the rows in use, each
// row covered is a read then a write of the single-port-pair RAM, and a
// closing check ends the walk. An unused mode is accepted and ignored. Results
// wait in an output register; a read item stays until that register is free.
// ----------------------------------------------------------------------------
module segment_coverage_histogram
	import sch_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// item channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           mode,
	input  logic [VAL_W-1:0]     sample,
	input  logic [IDX_W-1:0]     bin_index,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OUT_W-1:0]     bin_count,
	output logic [OUT_W-1:0]     peak_count,
	// configuration channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [VAL_W-1:0]     cfg_data
);

`include "segment_coverage_histogram_macros.svh"

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_CLEAR  = 9'b000000010,
		ST_DIFF   = 9'b000000100,
		ST_MUL    = 9'b000001000,
		ST_ROW    = 9'b000010000,
		ST_ORDER  = 9'b000100000,
		ST_RMW_RD = 9'b001000000,
		ST_RMW_WR = 9'b010000000,
		ST_READ   = 9'b100000000
	} state_t;

	state_t                    state_q;

	// configuration
	logic [VAL_W-1:0]          low_limit_q;
	logic [VAL_W-1:0]          rows_per_unit_q;
	logic [ROW_CNT_W-1:0]      row_count_q;

	// segment state
	logic [VAL_W-1:0]          prev_q;
	logic                      have_prev_q;
	logic [VAL_W-1:0]          opa_q;
	logic                      op_b_q;
	logic signed [ROW_S_W-1:0] row_a_q;
	logic [LIM_W-1:0]          y_q;
	logic [LIM_W-1:0]          end_q;
	logic [COUNT_BITS-1:0]     peak_q;
	logic [ROW_W-1:0]          clr_q;
	logic                      oob_q;

	// result register
	logic                      out_valid_q;
	logic [OUT_W-1:0]          bin_count_q;
	logic [OUT_W-1:0]          peak_count_q;

	// RAM and projection unit connections
	logic                      ram_we;
	logic [ROW_W-1:0]          ram_waddr;
	logic [COUNT_BITS-1:0]     ram_wdata;
	logic                      ram_re;
	logic [ROW_W-1:0]          ram_raddr;
	logic [COUNT_BITS-1:0]     ram_rdata;
	logic [COUNT_BITS-1:0]     cnt_inc;
	sch_proj_ctrl_t            proj_ctrl;
	logic [VAL_W-1:0]          proj_op;
	logic signed [ROW_S_W-1:0] proj_row;

	// segment ordering and clamping
	logic [LIM_W-1:0]          lim;
	logic signed [ROW_S_W-1:0] lim_s;
	logic signed [ROW_S_W-1:0] seg_lo;
	logic signed [ROW_S_W-1:0] seg_hi;
	logic                      seg_skip;
	logic [LIM_W-1:0]          lo_c;
	logic [LIM_W-1:0]          hi_c;
	logic                      in_xfer;
	logic                      out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_READ) && (!out_valid_q || out_ready);

	assign out_valid  = out_valid_q;
	assign bin_count  = bin_count_q;
	assign peak_count = peak_count_q;

	// clamp limit: row_count capped at the store depth
	always_comb begin
		lim = (row_count_q > ROW_CNT_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS) : LIM_W'(row_count_q);
		lim_s = $signed(ROW_S_W'(lim));
	end

	// order the two rows, drop or clamp the segment
	always_comb begin
		if (row_a_q > proj_row) begin
			seg_lo = proj_row;
			seg_hi = row_a_q;
		end else begin
			seg_lo = row_a_q;
			seg_hi = proj_row;
		end
		seg_skip = (seg_hi < 0) || (seg_lo > lim_s);
		lo_c = (seg_lo < 0) ? '0 : seg_lo[LIM_W-1:0];
		hi_c = (seg_hi > lim_s) ? lim : seg_hi[LIM_W-1:0];
	end

	// saturating increment of the fetched count
	assign cnt_inc = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;

	// projection unit steps and operand
	always_comb begin
		proj_ctrl.diff_en = (state_q == ST_DIFF);
		proj_ctrl.mul_en  = (state_q == ST_MUL);
		proj_ctrl.row_en  = (state_q == ST_ROW);
		proj_op = op_b_q ? prev_q : opa_q;
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = y_q[ROW_W-1:0];
		ram_wdata = cnt_inc;
		ram_re    = 1'b0;
		ram_raddr = y_q[ROW_W-1:0];
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == ST_RMW_WR) begin
			ram_we = 1'b1;
		end else if (state_q == ST_RMW_RD) begin
			ram_re = (y_q < end_q);
		end else if (in_xfer && mode == MODE_READ) begin
			ram_re    = 1'b1;
			ram_raddr = ROW_W'(bin_index);
		end
	end

	sch_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(MAX_ROWS)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	sch_proj u_proj (
		.clk          (clk),
		.ctrl         (proj_ctrl),
		.operand      (proj_op),
		.low_limit    (low_limit_q),
		.rows_per_unit(rows_per_unit_q),
		.row          (proj_row)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q     <= '0;
			rows_per_unit_q <= VAL_W'(65536);
			row_count_q     <= ROW_CNT_W'(1024);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOW_LIMIT:     low_limit_q     <= cfg_data;
				REG_ROWS_PER_UNIT: rows_per_unit_q <= cfg_data;
				REG_ROW_COUNT:     row_count_q     <= cfg_data[ROW_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			have_prev_q <= 1'b0;
			prev_q      <= '0;
			peak_q      <= '0;
			op_b_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						unique case (mode)
							MODE_ADD: begin
								prev_q      <= sample;
								have_prev_q <= 1'b1;
								if (have_prev_q) begin
									opa_q   <= prev_q;
									op_b_q  <= 1'b0;
									state_q <= ST_DIFF;
								end
							end
							MODE_READ: begin
								oob_q   <= ({1'b0, bin_index} >= (IDX_W + 1)'(MAX_ROWS));
								state_q <= ST_READ;
							end
							MODE_CLEAR: begin
								peak_q      <= '0;
								have_prev_q <= 1'b0;
								clr_q       <= '0;
								state_q     <= ST_CLEAR;
							end
							default: ;
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ROW_W'(MAX_ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIFF: begin
					// row of the older sample is ready when the second pass starts
					if (op_b_q) begin
						row_a_q <= proj_row;
					end
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					if (op_b_q) begin
						state_q <= ST_ORDER;
					end else begin
						op_b_q  <= 1'b1;
						state_q <= ST_DIFF;
					end
				end
				ST_ORDER: begin
					y_q   <= lo_c;
					end_q <= hi_c;
					state_q <= seg_skip ? ST_IDLE : ST_RMW_RD;
				end
				ST_RMW_RD: begin
					state_q <= (y_q < end_q) ? ST_RMW_WR : ST_IDLE;
				end
				ST_RMW_WR: begin
					if (cnt_inc > peak_q) begin
						peak_q <= cnt_inc;
					end
					y_q     <= y_q + 1'b1;
					state_q <= ST_RMW_RD;
				end
				ST_READ: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			bin_count_q  <= oob_q ? '0 : OUT_W'(ram_rdata);
			peak_count_q <= OUT_W'(peak_q);
		end
	end

	// checks
	`SCH_ASSERT_NXT(a_peak_covers_bin, state_q == ST_RMW_WR, peak_q >= $past(ram_rdata), "peak below an updated bin")
	`SCH_ASSERT_IMP(a_row_in_range, state_q == ST_RMW_RD || state_q == ST_RMW_WR, y_q <= end_q && end_q <= lim, "row walk past segment end")
	`SCH_ASSERT_NXT(a_clear_holds, state_q == ST_CLEAR, peak_q == '0 && !have_prev_q, "peak or previous sample set during clear")

endmodule

>>> hw/rtl/sch_ram.sv
// ----------------------------------------------------------------------------
// Segment coverage histogram: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sch_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/sch_proj.sv
// ----------------------------------------------------------------------------
// Segment coverage histogram: projection unit
// Maps a Q16.16 value to a signed row in three registered steps:
// difference and magnitude, 32x32 multiply, sign restore of the integer part.
// ----------------------------------------------------------------------------
module sch_proj
	import sch_pkg::*;
(
	input  logic                      clk,
	input  sch_proj_ctrl_t            ctrl,
	input  logic [VAL_W-1:0]          operand,
	input  logic [VAL_W-1:0]          low_limit,
	input  logic [VAL_W-1:0]          rows_per_unit,
	output logic signed [ROW_S_W-1:0] row
);

	logic signed [VAL_W:0]       diff;
	logic [VAL_W:0]              mag;
	logic [VAL_W-1:0]            mag_q;
	logic                        neg_q;
	logic                        neg_s2;
	logic [2*VAL_W-1:0]          prod_q;
	logic [ROW_S_W-1:0]          row_mag;
	logic signed [ROW_S_W-1:0]   row_q;

	// exact 33-bit difference; magnitude always fits 32 bits
	always_comb begin
		diff = $signed({operand[VAL_W-1], operand}) - $signed({low_limit[VAL_W-1], low_limit});
		mag  = diff[VAL_W] ? (VAL_W + 1)'(-diff) : (VAL_W + 1)'(diff);
	end

	assign row_mag = {1'b0, prod_q[2*VAL_W-1:VAL_W]};

	always_ff @(posedge clk) begin
		// step 1: magnitude and sign
		if (ctrl.diff_en) begin
			mag_q <= mag[VAL_W-1:0];
			neg_q <= diff[VAL_W];
		end
		// step 2: Q32.32 product
		if (ctrl.mul_en) begin
			prod_q <= (2 * VAL_W)'(mag_q) * (2 * VAL_W)'(rows_per_unit);
			neg_s2 <= neg_q;
		end
		// step 3: truncate toward zero and restore sign
		if (ctrl.row_en) begin
			row_q <= neg_s2 ? -$signed(row_mag) : $signed(row_mag);
		end
	end

	assign row = row_q;

endmodule
